/* design/vtp_pkg.sv */
package vtp_pkg;

  // Fields are carried at the full port width; the low DATA_WIDTH bits hold the value.
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned QUEUE_DEPTH = 8;

  localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
    64'h0000_0001_0000_0000, 64'h0,
    64'h0001_0000_0000_0000, 64'h0,
    64'h0,                   64'h0000_0001_0000_0000,
    64'h0,                   64'h0001_0000_0000_0000
  };

  typedef struct packed {
    logic [FIELD_W-1:0] in_x;
    logic [FIELD_W-1:0] in_y;
    logic [FIELD_W-1:0] in_z;
    logic [FIELD_W-1:0] in_w;
    logic               do_divide;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] out_x;
    logic [FIELD_W-1:0] out_y;
    logic [FIELD_W-1:0] out_z;
    logic [FIELD_W-1:0] out_w;
    logic               divided;
    logic               saturated;
  } out_item_t;

  // Transformed vertex handed from the front to the back.
  typedef struct packed {
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
    logic [FIELD_W-1:0] z;
    logic [FIELD_W-1:0] w;
    logic               div_req;
    logic               sat;
  } xfm_item_t;

endpackage

/* design/vtp_front.sv */
module vtp_front #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [vtp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [vtp_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_push,
  output logic                        in_full,
  input  vtp_pkg::in_item_t           in_data,
  input  logic [$clog2(vtp_pkg::QUEUE_DEPTH+1)-1:0] q_count,
  output logic                        xfm_valid,
  output vtp_pkg::xfm_item_t          xfm_item
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned SW = 2 * W + 3;
  localparam int unsigned CW = $clog2(vtp_pkg::QUEUE_DEPTH + 1);
  localparam logic signed [SW-1:0] RND = SW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] HI  = (SW'(1) << (W - 1)) - SW'(1);
  localparam logic signed [SW-1:0] LO  = -HI - SW'(1);

  logic [vtp_pkg::CFG_W-1:0] cfg_r [vtp_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vtp_pkg::NUM_REGS; i++) cfg_r[i] <= vtp_pkg::CFG_RESET[i];
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  logic [W-1:0] vin [4];
  assign vin[0] = in_data.in_x[W-1:0];
  assign vin[1] = in_data.in_y[W-1:0];
  assign vin[2] = in_data.in_z[W-1:0];
  assign vin[3] = in_data.in_w[W-1:0];

  logic                 v1_r, v2_r, v3_r;
  logic                 dd1_r, dd2_r;
  logic signed [PW-1:0] prod_r [4][4];
  logic signed [SW-1:0] sum_r [4];
  logic [W-1:0]         t_r [4];
  logic                 dd3_r, sat3_r;

  logic [CW-1:0] inflight;
  logic          accept;

  assign inflight = CW'(v1_r) + CW'(v2_r) + CW'(v3_r);
  assign in_full  = (q_count + inflight) >= CW'(vtp_pkg::QUEUE_DEPTH);
  assign accept   = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage 1: sixteen element products.
  always_ff @(posedge clk) begin
    dd1_r <= in_data.do_divide;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod_r[r][c] <= $signed(cfg_r[r*2 + c/2][32*(c%2) +: W]) * $signed(vin[c]);
      end
    end
  end

  // Stage 2: row sums with the rounding offset.
  always_ff @(posedge clk) begin
    dd2_r <= dd1_r;
    for (int r = 0; r < 4; r++) begin
      sum_r[r] <= SW'(prod_r[r][0]) + SW'(prod_r[r][1]) + SW'(prod_r[r][2])
                + SW'(prod_r[r][3]) + RND;
    end
  end

  // Stage 3: drop the extra fraction bits and clamp.
  logic signed [SW-1:0] sh [4];
  logic [W-1:0]         t_nxt [4];
  logic                 sat_nxt;

  always_comb begin
    sat_nxt = 1'b0;
    for (int r = 0; r < 4; r++) begin
      sh[r] = sum_r[r] >>> FRAC_BITS;
      if (sh[r] > HI) begin
        t_nxt[r] = HI[W-1:0];
        sat_nxt  = 1'b1;
      end else if (sh[r] < LO) begin
        t_nxt[r] = LO[W-1:0];
        sat_nxt  = 1'b1;
      end else begin
        t_nxt[r] = sh[r][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    dd3_r  <= dd2_r;
    sat3_r <= sat_nxt;
    for (int r = 0; r < 4; r++) t_r[r] <= t_nxt[r];
  end

  assign xfm_valid        = v3_r;
  assign xfm_item.x       = vtp_pkg::FIELD_W'($signed(t_r[0]));
  assign xfm_item.y       = vtp_pkg::FIELD_W'($signed(t_r[1]));
  assign xfm_item.z       = vtp_pkg::FIELD_W'($signed(t_r[2]));
  assign xfm_item.w       = vtp_pkg::FIELD_W'($signed(t_r[3]));
  assign xfm_item.div_req = dd3_r && (t_r[3] != '0);
  assign xfm_item.sat     = sat3_r;

endmodule

/* design/vtp_queue.sv */
module vtp_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  vtp_pkg::xfm_item_t       push_item,
  input  logic                     pop,
  output logic                     empty,
  output vtp_pkg::xfm_item_t       head,
  output logic [$clog2(vtp_pkg::QUEUE_DEPTH+1)-1:0] count
);

  localparam int unsigned D  = vtp_pkg::QUEUE_DEPTH;
  localparam int unsigned AW = $clog2(D);
  localparam int unsigned CW = $clog2(D + 1);

  vtp_pkg::xfm_item_t mem [D];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  // The front never pushes without room, so no full check here.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + AW'(1);
      count_r <= count_r + CW'(push) - CW'(pop);
    end
  end

  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];
  assign count = count_r;

endmodule

/* design/vtp_back.sv */
module vtp_back #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  vtp_pkg::xfm_item_t q_head,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output vtp_pkg::out_item_t out_data
);

  localparam int unsigned W = DATA_WIDTH;
  localparam int unsigned N = DATA_WIDTH + FRAC_BITS;
  localparam logic [N-1:0] QMAX_POS = N'((N'(1) << (W - 1)) - N'(1));
  localparam logic [N-1:0] QMAX_NEG = N'(1) << (W - 1);

  logic en;
  logic v_r [N+2];

  assign en    = !v_r[N+1] || out_pop;
  assign q_pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N + 2; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= !q_empty;
      for (int k = 1; k < N + 2; k++) v_r[k] <= v_r[k-1];
    end
  end

  // Per-stage payload: remainder, numerator shifting into quotient, sign and
  // the undivided value for each of x, y, z.
  logic [W-1:0] rem_r  [N+1][3];
  logic [N-1:0] num_r  [N+1][3];
  logic         neg_r  [N+1][3];
  logic [W-1:0] t_r    [N+1][3];
  logic [W-1:0] d_r    [N+1];
  logic [W-1:0] w_r    [N+1];
  logic         div_r  [N+1];
  logic         sat_r  [N+1];

  logic [W-1:0] tin [3];
  logic [W-1:0] win;
  assign tin[0] = q_head.x[W-1:0];
  assign tin[1] = q_head.y[W-1:0];
  assign tin[2] = q_head.z[W-1:0];
  assign win    = q_head.w[W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0]   <= win[W-1] ? -win : win;
      w_r[0]   <= win;
      div_r[0] <= q_head.div_req;
      sat_r[0] <= q_head.sat;
      for (int i = 0; i < 3; i++) begin
        rem_r[0][i] <= '0;
        num_r[0][i] <= {(tin[i][W-1] ? -tin[i] : tin[i]), FRAC_BITS'(0)};
        neg_r[0][i] <= tin[i][W-1] ^ win[W-1];
        t_r[0][i]   <= tin[i];
      end
    end
  end

  // One restoring quotient bit per stage.
  for (genvar k = 1; k <= N; k++) begin : g_step
    logic [W:0] trial [3];
    logic       qbit  [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = {rem_r[k-1][i], num_r[k-1][i][N-1]};
        qbit[i]  = trial[i] >= {1'b0, d_r[k-1]};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d_r[k]   <= d_r[k-1];
        w_r[k]   <= w_r[k-1];
        div_r[k] <= div_r[k-1];
        sat_r[k] <= sat_r[k-1];
        for (int i = 0; i < 3; i++) begin
          rem_r[k][i] <= qbit[i] ? W'(trial[i] - {1'b0, d_r[k-1]}) : trial[i][W-1:0];
          num_r[k][i] <= {num_r[k-1][i][N-2:0], qbit[i]};
          neg_r[k][i] <= neg_r[k-1][i];
          t_r[k][i]   <= t_r[k-1][i];
        end
      end
    end
  end

  // Final stage: sign and clamp the quotients, pass undivided values through, and hold the result.
  logic [W-1:0] res [3];
  logic         sat_fin;
  logic [N-1:0] q   [3];

  always_comb begin
    sat_fin = sat_r[N];
    for (int i = 0; i < 3; i++) begin
      q[i] = num_r[N][i];
      if (!div_r[N]) begin
        res[i] = t_r[N][i];
      end else if (!neg_r[N][i] && q[i] > QMAX_POS) begin
        res[i]  = QMAX_POS[W-1:0];
        sat_fin = 1'b1;
      end else if (neg_r[N][i] && q[i] > QMAX_NEG) begin
        res[i]  = QMAX_NEG[W-1:0];
        sat_fin = 1'b1;
      end else begin
        res[i] = neg_r[N][i] ? -q[i][W-1:0] : q[i][W-1:0];
      end
    end
  end

  vtp_pkg::out_item_t out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.out_x     <= vtp_pkg::FIELD_W'($signed(res[0]));
      out_r.out_y     <= vtp_pkg::FIELD_W'($signed(res[1]));
      out_r.out_z     <= vtp_pkg::FIELD_W'($signed(res[2]));
      out_r.out_w     <= vtp_pkg::FIELD_W'($signed(w_r[N]));
      out_r.divided   <= div_r[N];
      out_r.saturated <= sat_fin;
    end
  end

  assign out_empty = !v_r[N+1];
  assign out_data  = out_r;

endmodule

/* design/vertex_transform_project.sv */
// Transforms one homogeneous vertex per beat by the 4x4 Q-format matrix held in the
// eight configuration registers, with an optional divide of x, y and z by the
// transformed w. A new vertex is taken every cycle while results are drained. A vertex
// passes the multiply and sum pipeline (products, row sums, clamp), a small queue, and
// then the divide pipeline: an input register, one restoring quotient stage per quotient
// bit, and an output register. A vertex that needs no divide takes the same path
// and latency.
module vertex_transform_project #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [vtp_pkg::IDX_W-1:0] cfg_index,
  input  logic [vtp_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_push,
  output logic                      in_full,
  input  vtp_pkg::in_item_t         in_data,
  output logic                      out_empty,
  input  logic                      out_pop,
  output vtp_pkg::out_item_t        out_data
);

  logic               xfm_valid;
  vtp_pkg::xfm_item_t xfm_item;
  logic               q_empty, q_pop;
  vtp_pkg::xfm_item_t q_head;
  logic [$clog2(vtp_pkg::QUEUE_DEPTH+1)-1:0] q_count;

  vtp_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .q_count   (q_count),
    .xfm_valid (xfm_valid),
    .xfm_item  (xfm_item)
  );

  vtp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (xfm_valid),
    .push_item (xfm_item),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head),
    .count     (q_count)
  );

  vtp_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

/* bench/tb_vertex_transform_project.sv */
`timescale 1ns / 100ps

module tb_vertex_transform_project;

  typedef enum int unsigned {
    R0_C01 = 0, R0_C23 = 1, R1_C01 = 2, R1_C23 = 3,
    R2_C01 = 4, R2_C23 = 5, R3_C01 = 6, R3_C23 = 7
  } reg_idx_t;

  localparam int unsigned LATENCY = 80;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [vtp_pkg::IDX_W-1:0] cfg_index;
  logic [vtp_pkg::CFG_W-1:0] cfg_data;
  logic in_push;
  logic in_full;
  vtp_pkg::in_item_t in_data;
  logic out_empty;
  logic out_pop;
  vtp_pkg::out_item_t out_data;

  vertex_transform_project DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  logic [vtp_pkg::CFG_W-1:0] matrix_regs [vtp_pkg::NUM_REGS];
  vtp_pkg::in_item_t vertex_queue[$];
  vtp_pkg::out_item_t expected_vertices[$];
  int unsigned error_count;
  int unsigned beats_in;
  int unsigned beats_out;
  int unsigned divided_seen;
  int unsigned saturated_seen;
  int unsigned zero_w_seen;
  bit hold_off;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [31:0] matrix_elem(int unsigned r, int unsigned c);
    logic [vtp_pkg::CFG_W-1:0] word;
    word = matrix_regs[r * 2 + c / 2];
    return (c % 2) ? word[63:32] : word[31:0];
  endfunction

  function automatic logic signed [63:0] clamp32(logic signed [127:0] v, ref bit sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v[63:0];
  endfunction

  function automatic vtp_pkg::out_item_t transform_vertex(vtp_pkg::in_item_t v);
    vtp_pkg::out_item_t res;
    logic signed [63:0] comp [4];
    logic signed [63:0] t [4];
    logic signed [127:0] acc;
    logic signed [127:0] num;
    bit sat;
    sat = 1'b0;
    comp[0] = $signed(v.in_x);
    comp[1] = $signed(v.in_y);
    comp[2] = $signed(v.in_z);
    comp[3] = $signed(v.in_w);
    for (int r = 0; r < 4; r++) begin
      acc = 128'sd32768;
      for (int c = 0; c < 4; c++) begin
        acc = acc + 128'(matrix_elem(r, c)) * 128'(comp[c]);
      end
      t[r] = clamp32(acc >>> 16, sat);
    end
    res.divided = 1'b0;
    if (v.do_divide && t[3] != 0) begin
      res.divided = 1'b1;
      for (int i = 0; i < 3; i++) begin
        num = 128'(t[i]) * 128'sd65536;
        t[i] = clamp32(num / 128'(t[3]), sat);
      end
    end
    res.out_x = t[0][31:0];
    res.out_y = t[1][31:0];
    res.out_z = t[2][31:0];
    res.out_w = t[3][31:0];
    res.saturated = sat;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on beat %0d: %s got %h, expected %h", beats_out, field, got, want);
    error_count++;
  endtask

  // Driver: an accepted beat is predicted at the edge where it is taken.
  int unsigned send_gap;
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      expected_vertices.push_back(transform_vertex(in_data));
      if (in_data.do_divide && in_data.in_w == 0) zero_w_seen++;
      beats_in++;
      void'(vertex_queue.pop_front());
      send_gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 17) : 0;
    end else if (send_gap != 0 && !(in_push && in_full)) begin
      send_gap <= send_gap - 1;
    end
  end

  // The head of the queue is always the beat not yet taken, so a stalled beat stays put.
  always @(negedge clk) begin
    if (rst_n && vertex_queue.size() != 0 && send_gap == 0) begin
      in_push <= 1'b1;
      in_data <= vertex_queue[0];
    end else begin
      in_push <= 1'b0;
    end
  end

  // Monitor: compares each popped beat against the oldest prediction.
  int unsigned pop_gap;
  vtp_pkg::out_item_t want;
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      beats_out++;
      if (expected_vertices.size() == 0) begin
        $display("unexpected result beat %0d", beats_out);
        error_count++;
      end else begin
        want = expected_vertices.pop_front();
        if (out_data.out_x !== want.out_x) report_mismatch("x", out_data.out_x, want.out_x);
        if (out_data.out_y !== want.out_y) report_mismatch("y", out_data.out_y, want.out_y);
        if (out_data.out_z !== want.out_z) report_mismatch("z", out_data.out_z, want.out_z);
        if (out_data.out_w !== want.out_w) report_mismatch("w", out_data.out_w, want.out_w);
        if (out_data.divided !== want.divided)
          report_mismatch("divided", out_data.divided, want.divided);
        if (out_data.saturated !== want.saturated)
          report_mismatch("saturated", out_data.saturated, want.saturated);
        if (want.divided) divided_seen++;
        if (want.saturated) saturated_seen++;
      end
      pop_gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 17) : 0;
    end else if (pop_gap != 0) begin
      pop_gap <= pop_gap - 1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && !hold_off && pop_gap == 0 && !(out_pop && !out_empty))
      out_pop <= 1'b1;
    else if (rst_n && !hold_off && pop_gap == 0 && out_pop)
      out_pop <= 1'b1;
    else
      out_pop <= 1'b0;
  end

  task automatic write_reg(reg_idx_t idx, logic [vtp_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = vtp_pkg::IDX_W'(idx);
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    matrix_regs[idx] = value;
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
      4: return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic vtp_pkg::in_item_t make_vertex(logic [31:0] x, logic [31:0] y,
                                                    logic [31:0] z, logic [31:0] w,
                                                    logic d);
    vtp_pkg::in_item_t v;
    v.in_x = x;
    v.in_y = y;
    v.in_z = z;
    v.in_w = w;
    v.do_divide = d;
    return v;
  endfunction

  task automatic drain();
    while (vertex_queue.size() != 0 || expected_vertices.size() != 0 || in_push)
      @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic load_matrix(int unsigned style);
    for (int i = 0; i < vtp_pkg::NUM_REGS; i++) begin
      case (style)
        0: write_reg(reg_idx_t'(i), vtp_pkg::CFG_RESET[i]);
        1: write_reg(reg_idx_t'(i), {2{32'h7fff_ffff}});
        2: write_reg(reg_idx_t'(i), {2{32'h8000_0000}});
        3: write_reg(reg_idx_t'(i), {$urandom_range(0, 32'h0003_ffff) - 32'h0002_0000,
                                     $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000});
        default: write_reg(reg_idx_t'(i), {$urandom, $urandom});
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    hold_off = 1'b0;
    send_gap = 0;
    pop_gap = 0;
    error_count = 0;
    beats_in = 0;
    beats_out = 0;
    divided_seen = 0;
    saturated_seen = 0;
    zero_w_seen = 0;
    for (int i = 0; i < vtp_pkg::NUM_REGS; i++) matrix_regs[i] = vtp_pkg::CFG_RESET[i];
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed vertices under the reset matrix.
    vertex_queue.push_back(make_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                                       32'h0001_0000, 1'b0));
    vertex_queue.push_back(make_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                                       32'h0002_0000, 1'b1));
    vertex_queue.push_back(make_vertex(32'h0005_0000, 32'hfffb_0000, 32'h1, 32'h0, 1'b1));
    vertex_queue.push_back(make_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                       32'h1, 1'b1));
    vertex_queue.push_back(make_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                       32'hffff_ffff, 1'b1));
    vertex_queue.push_back(make_vertex(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                       32'h8000_0000, 1'b1));
    vertex_queue.push_back(make_vertex(32'h0, 32'h0, 32'h0, 32'h0, 1'b0));
    vertex_queue.push_back(make_vertex(32'h0000_8000, 32'hffff_8000, 32'h0000_7fff,
                                       32'h7fff_ffff, 1'b1));
    drain();

    // Extreme matrices drive the sums past the range.
    for (int style = 1; style <= 2; style++) begin
      load_matrix(style);
      vertex_queue.push_back(make_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                         32'h7fff_ffff, 1'b1));
      vertex_queue.push_back(make_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                         32'h8000_0000, 1'b1));
      vertex_queue.push_back(make_vertex(32'h1, 32'h0, 32'h0, 32'h0, 1'b1));
      vertex_queue.push_back(make_vertex(32'h0001_0000, 32'hffff_0000, 32'h0, 32'h0, 1'b0));
      drain();
    end

    // Random phases, each loading a matrix of one of five styles in turn.
    for (int phase = 0; phase < 12; phase++) begin
      load_matrix(phase % 5);
      for (int n = 0; n < 150; n++)
        vertex_queue.push_back(make_vertex(rand_field(), rand_field(), rand_field(),
                                           rand_field(), $urandom_range(0, 3) != 0));
      if (phase == 3) begin
        // Hold off the receiver long enough for the block to fill and assert full.
        hold_off = 1'b1;
        for (int c = 0; c < 400; c++) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end

    $display("%0d vertices sent, %0d results checked over 15 matrix settings",
             beats_in, beats_out);
    $display("%0d divided, %0d saturated, %0d zero-w divide requests",
             divided_seen, saturated_seen, zero_w_seen);
    if (error_count == 0 && expected_vertices.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
design/vtp_pkg.sv
design/vtp_front.sv
design/vtp_queue.sv
design/vtp_back.sv
design/vertex_transform_project.sv
bench/tb_vertex_transform_project.sv
